@@ sv/kst_pkg.sv @@
// Package for the keyed slot table with overflow queue.
// Holds field widths, default depths and the status codes.
// No dependencies.
package kst_pkg;

  // Default sizes of the slot list and the waiting queue.
  localparam int unsigned SlotDepthDef = 8;
  localparam int unsigned WaitDepthDef = 8;

  // Field widths.
  localparam int unsigned KeyW    = 16;
  localparam int unsigned DepW    = 16;
  localparam int unsigned UsedW   = 4;
  localparam int unsigned StatusW = 3;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StPlaced   = 3'd0,
    StQueued   = 3'd1,
    StFull     = 3'd2,
    StDup      = 3'd3,
    StRemoved  = 3'd4,
    StNotFound = 3'd5
  } status_e;

endpackage

@@ sv/keyed_slot_table_with_overflow_queue.sv @@
// Channel | Direction | Signals
// --------+-----------+---------------------------------------------------------------
// in      | input     | in_valid_i, in_stall_o, command_i, plate_i
// out     | output    | out_valid_o, out_stall_i, status_o, promoted_valid_o,
//         |           | promoted_plate_o, departures_o, slots_used_o, waiting_used_o
//
// One item at a time: in_stall_o stays high until the result is in the output register,
// which holds it under out_stall_i while the next transfer is accepted.
// One shared comparator scans the slot list an entry per cycle over the registered RAM read:
// a search ends at the first match or the last entry (none when the list is empty), then acting
// and loading the result follow; a depart hit also moves each later entry down and promotes.
// Reset clears all counts and the queue head; the RAM contents need no clearing.
//
// Top level of the keyed slot table; uses kst_pkg and kst_ram.
module keyed_slot_table_with_overflow_queue #(
  parameter int unsigned SlotDepth = kst_pkg::SlotDepthDef,
  parameter int unsigned WaitDepth = kst_pkg::WaitDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [kst_pkg::KeyW-1:0]    plate_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kst_pkg::StatusW-1:0] status_o,
  output logic                        promoted_valid_o,
  output logic [kst_pkg::KeyW-1:0]    promoted_plate_o,
  output logic [kst_pkg::DepW-1:0]    departures_o,
  output logic [kst_pkg::UsedW-1:0]   slots_used_o,
  output logic [kst_pkg::UsedW-1:0]   waiting_used_o
);

  localparam int unsigned SAW = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int unsigned WAW = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int unsigned SCW = $clog2(SlotDepth + 1);
  localparam int unsigned WCW = $clog2(WaitDepth + 1);
  localparam int unsigned TW  = WCW + 1;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SAct,
    SShRd,
    SShWr,
    SPrRd,
    SPrWr,
    SFinish
  } state_e;

  state_e                      state_q;
  logic                        cmd_q;
  logic [kst_pkg::KeyW-1:0]    key_q;
  logic [SCW-1:0]              slot_cnt_q;
  logic [WCW-1:0]              wait_cnt_q;
  logic [WAW-1:0]              head_q;
  logic [kst_pkg::DepW-1:0]    dep_q;
  logic [SAW-1:0]              scan_idx_q;
  logic                        chk_vld_q;
  logic [SAW-1:0]              chk_idx_q;
  logic                        hit_q;
  logic [SCW-1:0]              shift_idx_q;
  kst_pkg::status_e            res_status_q;
  logic                        res_pval_q;
  logic [kst_pkg::KeyW-1:0]    res_pplate_q;
  logic                        out_valid_q;
  logic [kst_pkg::StatusW-1:0] out_status_q;
  logic                        out_pval_q;
  logic [kst_pkg::KeyW-1:0]    out_pplate_q;
  logic [kst_pkg::DepW-1:0]    out_dep_q;
  logic [kst_pkg::UsedW-1:0]   out_slots_q;
  logic [kst_pkg::UsedW-1:0]   out_wait_q;

  logic                     slot_we;
  logic [SAW-1:0]           slot_waddr;
  logic [kst_pkg::KeyW-1:0] slot_wdata;
  logic [SAW-1:0]           slot_raddr;
  logic [kst_pkg::KeyW-1:0] slot_rdata;
  logic                     wait_we;
  logic [WAW-1:0]           wait_waddr;
  logic [kst_pkg::KeyW-1:0] wait_rdata;
  logic [TW-1:0]            tail_sum;
  logic [WAW-1:0]           tail_idx;
  logic [SCW-1:0]           shift_nxt;
  logic                     key_match;
  logic                     in_xfer;
  logic                     out_free;
  logic                     out_load;

  assign in_xfer   = in_valid_i && (state_q == SIdle);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == SFinish) && out_free;
  assign shift_nxt = shift_idx_q + SCW'(1);
  assign key_match = (slot_rdata == key_q);

  // Tail of the waiting ring: head plus occupancy, wrapped at the depth.
  always_comb begin
    tail_sum = TW'(head_q) + TW'(wait_cnt_q);
    if (tail_sum >= TW'(WaitDepth)) begin
      tail_sum = tail_sum - TW'(WaitDepth);
    end
    tail_idx = WAW'(tail_sum);
  end

  // Slot RAM and waiting RAM port control, chosen by the sequencer state.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = SAW'(slot_cnt_q);
    slot_wdata = key_q;
    slot_raddr = scan_idx_q;
    wait_we    = 1'b0;
    wait_waddr = tail_idx;
    case (state_q)
      SAct: begin
        if (cmd_q == 1'b0 && !hit_q) begin
          if (slot_cnt_q < SCW'(SlotDepth)) begin
            slot_we = 1'b1;
          end else if (wait_cnt_q < WCW'(WaitDepth)) begin
            wait_we = 1'b1;
          end
        end
      end
      SShRd: begin
        slot_raddr = SAW'(shift_nxt);
      end
      SShWr: begin
        slot_we    = 1'b1;
        slot_waddr = SAW'(shift_idx_q);
        slot_wdata = slot_rdata;
      end
      SPrWr: begin
        slot_we    = 1'b1;
        slot_waddr = SAW'(slot_cnt_q);
        slot_wdata = wait_rdata;
      end
      default: begin
      end
    endcase
  end

  kst_ram #(
    .Width(kst_pkg::KeyW),
    .Depth(SlotDepth),
    .AddrW(SAW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  kst_ram #(
    .Width(kst_pkg::KeyW),
    .Depth(WaitDepth),
    .AddrW(WAW)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (wait_we),
    .waddr_i(wait_waddr),
    .wdata_i(key_q),
    .raddr_i(head_q),
    .rdata_o(wait_rdata)
  );

  // Sequencer: search, act, close the gap, promote, then hand the result over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      slot_cnt_q   <= '0;
      wait_cnt_q   <= '0;
      head_q       <= '0;
      dep_q        <= '0;
      chk_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      cmd_q        <= 1'b0;
      key_q        <= '0;
      scan_idx_q   <= '0;
      chk_idx_q    <= '0;
      shift_idx_q  <= '0;
      res_status_q <= kst_pkg::StPlaced;
      res_pval_q   <= 1'b0;
      res_pplate_q <= '0;
      out_status_q <= '0;
      out_pval_q   <= 1'b0;
      out_pplate_q <= '0;
      out_dep_q    <= '0;
      out_slots_q  <= '0;
      out_wait_q   <= '0;
    end else begin
      // The output register drains whenever the receiver does not stall and no new result
      // is loaded in the same cycle.
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        SIdle: begin
          if (in_xfer) begin
            cmd_q        <= command_i;
            key_q        <= plate_i;
            scan_idx_q   <= '0;
            chk_vld_q    <= 1'b0;
            hit_q        <= 1'b0;
            res_pval_q   <= 1'b0;
            res_pplate_q <= '0;
            state_q      <= (slot_cnt_q == '0) ? SAct : SScan;
          end
        end

        // One compare per cycle against the entry read in the previous cycle.
        SScan: begin
          chk_vld_q <= 1'b1;
          chk_idx_q <= scan_idx_q;
          if (scan_idx_q != SAW'(SlotDepth - 1)) begin
            scan_idx_q <= scan_idx_q + SAW'(1);
          end
          if (chk_vld_q) begin
            if (key_match) begin
              hit_q       <= 1'b1;
              shift_idx_q <= SCW'(chk_idx_q);
              state_q     <= SAct;
            end else if (SCW'(chk_idx_q) + SCW'(1) == slot_cnt_q) begin
              state_q <= SAct;
            end
          end
        end

        SAct: begin
          state_q <= (cmd_q == 1'b1 && hit_q) ? SShRd : SFinish;
          if (cmd_q == 1'b0) begin
            if (hit_q) begin
              res_status_q <= kst_pkg::StDup;
            end else if (slot_cnt_q < SCW'(SlotDepth)) begin
              slot_cnt_q   <= slot_cnt_q + SCW'(1);
              res_status_q <= kst_pkg::StPlaced;
            end else if (wait_cnt_q < WCW'(WaitDepth)) begin
              wait_cnt_q   <= wait_cnt_q + WCW'(1);
              res_status_q <= kst_pkg::StQueued;
            end else begin
              res_status_q <= kst_pkg::StFull;
            end
          end else if (hit_q) begin
            res_status_q <= kst_pkg::StRemoved;
          end else begin
            res_status_q <= kst_pkg::StNotFound;
          end
        end

        // Move the next entry down by one, or finish the removal.
        SShRd: begin
          if (shift_nxt < slot_cnt_q) begin
            state_q <= SShWr;
          end else begin
            slot_cnt_q <= slot_cnt_q - SCW'(1);
            if (dep_q != '1) begin
              dep_q <= dep_q + kst_pkg::DepW'(1);
            end
            state_q <= (wait_cnt_q != '0) ? SPrRd : SFinish;
          end
        end

        SShWr: begin
          shift_idx_q <= shift_nxt;
          state_q     <= SShRd;
        end

        // Queue head is being read from the waiting RAM.
        SPrRd: begin
          state_q <= SPrWr;
        end

        SPrWr: begin
          slot_cnt_q   <= slot_cnt_q + SCW'(1);
          wait_cnt_q   <= wait_cnt_q - WCW'(1);
          head_q       <= (head_q == WAW'(WaitDepth - 1)) ? '0 : head_q + WAW'(1);
          res_pval_q   <= 1'b1;
          res_pplate_q <= wait_rdata;
          state_q      <= SFinish;
        end

        // Load the output register once it is free.
        SFinish: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_pval_q   <= res_pval_q;
            out_pplate_q <= res_pplate_q;
            out_dep_q    <= dep_q;
            out_slots_q  <= kst_pkg::UsedW'(slot_cnt_q);
            out_wait_q   <= kst_pkg::UsedW'(wait_cnt_q);
            state_q      <= SIdle;
          end
        end

        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != SIdle);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign promoted_valid_o = out_pval_q;
  assign promoted_plate_o = out_pplate_q;
  assign departures_o     = out_dep_q;
  assign slots_used_o     = out_slots_q;
  assign waiting_used_o   = out_wait_q;

endmodule

@@ sv/kst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot list and the waiting queue; no dependencies.
module kst_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ tb/sv/keyed_slot_table_with_overflow_queue_tb.sv @@
// Self-checking testbench for keyed_slot_table_with_overflow_queue.
// A scoreboard class predicts every result from the accepted transfers.
// Depends on kst_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef enum bit {
  CmdArrive = 1'b0,
  CmdDepart = 1'b1
} slot_cmd_e;

typedef struct {
  kst_pkg::status_e          status;
  logic                      promoted_valid;
  logic [kst_pkg::KeyW-1:0]  promoted_plate;
  logic [kst_pkg::DepW-1:0]  departures;
  logic [kst_pkg::UsedW-1:0] slots_used;
  logic [kst_pkg::UsedW-1:0] waiting_used;
} slot_result_t;

// Mirror of the slot list and waiting queue plus the results still owed by the block.
class slot_table_scoreboard;
  logic [kst_pkg::KeyW-1:0] slot_keys [kst_pkg::SlotDepthDef];
  logic [kst_pkg::KeyW-1:0] wait_keys [kst_pkg::WaitDepthDef];
  int unsigned              slot_count;
  int unsigned              wait_count;
  logic [kst_pkg::DepW-1:0] removals;
  slot_result_t             pending_results [$];
  int unsigned              errors;
  int unsigned              results_seen;

  function new();
    slot_count   = 0;
    wait_count   = 0;
    removals     = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  // Apply one accepted transfer to the mirror and queue the result it must produce.
  function void apply_command(slot_cmd_e cmd, logic [kst_pkg::KeyW-1:0] key);
    slot_result_t r;
    int           pos;
    pos              = -1;
    r.promoted_valid = 1'b0;
    r.promoted_plate = '0;
    for (int i = 0; i < slot_count; i++) begin
      if (pos < 0 && slot_keys[i] == key) pos = i;
    end
    if (cmd == CmdArrive) begin
      if (pos >= 0) begin
        r.status = kst_pkg::StDup;
      end else if (slot_count < kst_pkg::SlotDepthDef) begin
        slot_keys[slot_count] = key;
        slot_count++;
        r.status = kst_pkg::StPlaced;
      end else if (wait_count < kst_pkg::WaitDepthDef) begin
        wait_keys[wait_count] = key;
        wait_count++;
        r.status = kst_pkg::StQueued;
      end else begin
        r.status = kst_pkg::StFull;
      end
    end else if (pos >= 0) begin
      // Close the gap, then pull the oldest waiting key into the freed last slot.
      for (int i = pos; i + 1 < slot_count; i++) slot_keys[i] = slot_keys[i+1];
      slot_count--;
      if (wait_count > 0) begin
        r.promoted_valid      = 1'b1;
        r.promoted_plate      = wait_keys[0];
        slot_keys[slot_count] = wait_keys[0];
        slot_count++;
        for (int i = 0; i + 1 < wait_count; i++) wait_keys[i] = wait_keys[i+1];
        wait_count--;
      end
      if (removals != '1) removals++;
      r.status = kst_pkg::StRemoved;
    end else begin
      r.status = kst_pkg::StNotFound;
    end
    r.departures   = removals;
    r.slots_used   = slot_count[kst_pkg::UsedW-1:0];
    r.waiting_used = wait_count[kst_pkg::UsedW-1:0];
    pending_results.push_back(r);
  endfunction

  // Print one line for each mismatch and count it.
  task report_mismatch(string msg);
    errors++;
    $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  // Compare one accepted result with the oldest pending prediction.
  task check_result(logic [kst_pkg::StatusW-1:0] st, logic pv,
                    logic [kst_pkg::KeyW-1:0] pp, logic [kst_pkg::DepW-1:0] dep,
                    logic [kst_pkg::UsedW-1:0] su, logic [kst_pkg::UsedW-1:0] wu);
    slot_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch("result arrived with no transfer outstanding");
    end else begin
      e = pending_results.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      if (pv !== e.promoted_valid)
        report_mismatch($sformatf("promoted_valid %0b, expected %0b", pv, e.promoted_valid));
      if (pp !== e.promoted_plate)
        report_mismatch($sformatf("promoted_plate %h, expected %h", pp, e.promoted_plate));
      if (dep !== e.departures)
        report_mismatch($sformatf("departures %0d, expected %0d", dep, e.departures));
      if (su !== e.slots_used)
        report_mismatch($sformatf("slots_used %0d, expected %0d", su, e.slots_used));
      if (wu !== e.waiting_used)
        report_mismatch($sformatf("waiting_used %0d, expected %0d", wu, e.waiting_used));
    end
    results_seen++;
  endtask
endclass

module keyed_slot_table_with_overflow_queue_tb;

  localparam int     RandItems    = 800;
  localparam int     HoldCycles   = 300;
  localparam int     DrainCycles  = 80;
  localparam int     TailPairs    = 16;
  localparam longint TimeoutNs    = 64'd5_000_000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        command;
  logic [kst_pkg::KeyW-1:0]    plate;
  logic                        out_valid;
  logic                        out_stall;
  logic [kst_pkg::StatusW-1:0] status;
  logic                        promoted_valid;
  logic [kst_pkg::KeyW-1:0]    promoted_plate;
  logic [kst_pkg::DepW-1:0]    departures;
  logic [kst_pkg::UsedW-1:0]   slots_used;
  logic [kst_pkg::UsedW-1:0]   waiting_used;

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int gap_pct  = 25;

  slot_table_scoreboard sb = new();

  keyed_slot_table_with_overflow_queue u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .plate_i          (plate),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .promoted_valid_o (promoted_valid),
    .promoted_plate_o (promoted_plate),
    .departures_o     (departures),
    .slots_used_o     (slots_used),
    .waiting_used_o   (waiting_used)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command, optionally after an idle burst, and wait for its transfer.
  task automatic send_item(slot_cmd_e cmd, logic [kst_pkg::KeyW-1:0] key);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    plate    <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_command(cmd, key);
  endtask

  // Receiver stall: random bursts, calm stretches, and one long hold on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(status, promoted_valid, promoted_plate, departures, slots_used,
                      waiting_used);
  end

  // Stimulus and end of run.
  initial begin
    slot_cmd_e                cmd;
    logic [kst_pkg::KeyW-1:0] key;
    int                       sel;
    int                       arrive_pct;
    in_valid   <= 1'b0;
    command    <= 1'b0;
    plate      <= '0;
    rst_n      <= 1'b0;
    arrive_pct = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty list, extreme keys, duplicates, promotion of a key queued twice
    // so that it sits twice in the slots, and both stores full.
    send_item(CmdDepart, 16'h0000);
    send_item(CmdArrive, 16'h0000);
    send_item(CmdArrive, 16'hFFFF);
    send_item(CmdArrive, 16'h0000);
    for (int k = 1; k <= 6; k++) send_item(CmdArrive, 16'(16'h0100 + k));
    send_item(CmdArrive, 16'hA5A5);
    send_item(CmdArrive, 16'hA5A5);
    send_item(CmdArrive, 16'hFFFF);
    send_item(CmdDepart, 16'h0000);
    send_item(CmdDepart, 16'hFFFF);
    send_item(CmdDepart, 16'hA5A5);
    send_item(CmdDepart, 16'hA5A5);
    send_item(CmdArrive, 16'h5A5A);
    send_item(CmdArrive, 16'h7FFF);
    for (int k = 0; k < 8; k++) send_item(CmdArrive, 16'(16'hC000 + k));
    send_item(CmdArrive, 16'h8000);
    send_item(CmdDepart, 16'hC003);

    // Random part: segments lean toward filling or draining; keys often come from the stores
    // or a small pool so that hits, duplicates and requeued keys are common.
    for (int n = 0; n < RandItems; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       arrive_pct = 85;
          1:       arrive_pct = 50;
          default: arrive_pct = 20;
        endcase
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      end
      if (n == 300) hold_req = 1'b1;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < arrive_pct) begin
        cmd = CmdArrive;
        if (sel < 20 && sb.slot_count > 0)
          key = sb.slot_keys[$urandom_range(0, sb.slot_count - 1)];
        else if (sel < 35 && sb.wait_count > 0)
          key = sb.wait_keys[$urandom_range(0, sb.wait_count - 1)];
        else if (sel < 60)
          key = 16'($urandom_range(0, 65535));
        else
          key = 16'(16'h5A00 + $urandom_range(0, 31));
      end else begin
        cmd = CmdDepart;
        if (sel < 65 && sb.slot_count > 0)
          key = sb.slot_keys[$urandom_range(0, sb.slot_count - 1)];
        else if (sel < 80 && sb.wait_count > 0)
          key = sb.wait_keys[$urandom_range(0, sb.wait_count - 1)];
        else if (sel < 90)
          key = 16'($urandom_range(0, 65535));
        else
          key = 16'(16'h5A00 + $urandom_range(0, 31));
      end
      send_item(cmd, key);
    end

    // Last part without idling: empty both stores, then a short run of back-to-back
    // arrive and depart pairs.
    quiet = 1'b1;
    while (sb.slot_count > 0) send_item(CmdDepart, sb.slot_keys[0]);
    for (int n = 0; n < TailPairs; n++) begin
      send_item(CmdArrive, 16'(n));
      send_item(CmdDepart, 16'(n));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TimeoutNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
